[rtl/core/bbre_pkg.sv]
package bbre_pkg;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_TAS   = 3'd2,
        MODE_EXTR  = 3'd3,
        MODE_COUNT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_WORK,
        ST_OUT
    } state_t;

    localparam int MODE_W   = 3;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int RESULT_W = 11;

    // word unit control from the sequencer
    typedef struct packed {
        logic [2:0] mode;
        logic       in_run;
        logic       done_run;
    } wop_t;

endpackage

[rtl/core/bbre_word_unit.sv]
// Per-word operation: builds the range mask, updates the word, counts bits
// and tracks the extract run within one word.
module bbre_word_unit #(
    parameter int WORD_BITS = 64,
    parameter int BW        = 17
) (
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [BW-1:0]        word_base,
    input  logic [BW-1:0]        lo,
    input  logic [BW:0]          hi,
    input  bbre_pkg::wop_t       op,
    output logic [WORD_BITS-1:0] word_out,
    output logic [$clog2(WORD_BITS+1)-1:0] ones,
    output logic                 found,
    output logic [$clog2(WORD_BITS)-1:0] first_pos,
    output logic                 run_ends
);
    localparam int PW = $clog2(WORD_BITS);
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] sel;
    logic [WORD_BITS-1:0] clr;
    logic                 clearing;
    logic                 stop;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = ({1'b0, word_base} + (BW+1)'(i) >= {1'b0, lo})
                   && ({1'b0, word_base} + (BW+1)'(i) < hi);
        end
    end

    assign sel = word_in & mask;

    always_comb begin
        ones = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            ones = ones + (PW+1)'(sel[i]);
        end
    end

    // extract: clear set bits from the run start until the first zero
    always_comb begin
        found     = 1'b0;
        first_pos = '0;
        for (int i = WORD_BITS-1; i >= 0; i--) begin
            if (word_in[i]) begin
                found     = 1'b1;
                first_pos = PW'(i);
            end
        end
        clr      = '0;
        clearing = op.in_run;
        stop     = 1'b0;
        run_ends = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!stop && !op.done_run) begin
                if (!clearing && !op.in_run && word_in[i]) clearing = 1'b1;
                if (clearing) begin
                    if (word_in[i]) begin
                        clr[i] = 1'b1;
                    end else begin
                        stop     = 1'b1;
                        run_ends = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        case (op.mode)
            bbre_pkg::MODE_INIT:                      word_out = mask;
            bbre_pkg::MODE_ADD, bbre_pkg::MODE_TAS:   word_out = word_in | mask;
            bbre_pkg::MODE_EXTR:                      word_out = word_in & ~clr;
            default:                                  word_out = word_in;
        endcase
    end
endmodule

[rtl/core/block_bitmap_range_engine.sv]
// Channel | Dir | tdata fields (low bit up)
// s_axis  | in  | mode[2:0], start_block[12:3], block_count[23:13]
// m_axis  | out | result_value[10:0], run_start[20:11], range_error[21]
//
// Every item walks all map words, one word at a time through a single
// word unit; a new item is not accepted until the last one's result is out.
// Memory read is registered, so each word takes read, wait and write steps.
// Reset clears the valid bit of every word; an invalid word reads as zero.
// s_tready is low from acceptance until the result beat is taken and the engine is back in ST_IDLE.
module block_bitmap_range_engine #(
    parameter int BLOCKS_PER_CHUNK = 1024,
    parameter int WORD_BITS        = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // mode, start_block, block_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // result_value, run_start, range_error
);
    localparam int NW = (BLOCKS_PER_CHUNK + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW = $clog2(BLOCKS_PER_CHUNK) + 1;
    localparam int PW = $clog2(WORD_BITS);
    localparam int RW = bbre_pkg::RESULT_W;
    localparam int SW = bbre_pkg::START_W;

    bbre_pkg::state_t state_reg, state_next;
    logic [2:0]    mode_reg;
    logic [BW-1:0] lo_reg;
    logic [BW:0]   hi_reg;
    logic          err_reg;
    logic [AW:0]   idx_reg;
    logic [RW-1:0] val_reg;
    logic [SW-1:0] rs_reg;
    logic          in_run_reg, done_run_reg;
    logic [NW-1:0] valid_reg;
    logic [WORD_BITS-1:0] mem [NW];
    logic [WORD_BITS-1:0] rd_reg;
    logic [23:0]   out_reg;
    logic          out_v_reg;

    logic [2:0]    in_mode;
    logic [bbre_pkg::START_W-1:0] in_start;
    logic [bbre_pkg::COUNT_W-1:0] in_count;
    logic [BW:0]   in_end;
    logic          in_err;

    assign in_mode  = s_tdata[2:0];
    assign in_start = s_tdata[12:3];
    assign in_count = s_tdata[23:13];
    assign in_end   = (BW+1)'(in_start) + (BW+1)'(in_count);

    always_comb begin
        case (in_mode)
            bbre_pkg::MODE_INIT, bbre_pkg::MODE_ADD, bbre_pkg::MODE_COUNT:
                in_err = (in_count == '0) || (in_end > (BW+1)'(BLOCKS_PER_CHUNK));
            bbre_pkg::MODE_TAS:
                in_err = (BW+1)'(in_start) >= (BW+1)'(BLOCKS_PER_CHUNK);
            default: in_err = 1'b0;
        endcase
    end

    logic [AW-1:0] widx;
    logic [WORD_BITS-1:0] w_in, w_out;
    logic [PW:0]   ones;
    logic          found, run_ends;
    logic [PW-1:0] first_pos;
    logic [BW-1:0] wbase;
    bbre_pkg::wop_t op;
    logic [RW-1:0] val_next;
    logic [SW-1:0] rs_next;

    assign widx  = idx_reg[AW-1:0];
    assign w_in  = valid_reg[widx] ? rd_reg : '0;
    assign wbase = BW'(widx) << PW;
    assign op    = '{mode: mode_reg, in_run: in_run_reg, done_run: done_run_reg};

    bbre_word_unit #(.WORD_BITS(WORD_BITS), .BW(BW)) u_word (
        .word_in(w_in), .word_base(wbase), .lo(lo_reg), .hi(hi_reg), .op(op),
        .word_out(w_out), .ones(ones), .found(found), .first_pos(first_pos),
        .run_ends(run_ends)
    );

    // running result including the word under work
    always_comb begin
        val_next = val_reg;
        rs_next  = rs_reg;
        if (!err_reg) begin
            if (mode_reg == bbre_pkg::MODE_COUNT || mode_reg == bbre_pkg::MODE_TAS)
                val_next = val_reg + RW'(ones);
            if (mode_reg == bbre_pkg::MODE_EXTR && !done_run_reg) begin
                if (!in_run_reg && found)
                    rs_next = SW'(wbase + BW'(first_pos));
                val_next = val_reg + RW'($countones(w_in & ~w_out));
            end
        end
    end

    logic last_word;
    assign last_word = (idx_reg == (AW+1)'(NW - 1));
    assign s_tready  = (state_reg == bbre_pkg::ST_IDLE);
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbre_pkg::ST_IDLE: if (s_tvalid) state_next = bbre_pkg::ST_READ;
            bbre_pkg::ST_READ: state_next = bbre_pkg::ST_WAIT;
            bbre_pkg::ST_WAIT: state_next = bbre_pkg::ST_WORK;
            bbre_pkg::ST_WORK: state_next = last_word ? bbre_pkg::ST_OUT
                                                      : bbre_pkg::ST_READ;
            bbre_pkg::ST_OUT:  if (!out_v_reg) state_next = bbre_pkg::ST_IDLE;
            default:           state_next = bbre_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bbre_pkg::ST_READ) rd_reg <= mem[widx];
        if (state_reg == bbre_pkg::ST_WORK && !err_reg) mem[widx] <= w_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbre_pkg::ST_IDLE;
            valid_reg <= '0;
            out_v_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                bbre_pkg::ST_IDLE: if (s_tvalid) begin
                    mode_reg     <= in_mode;
                    err_reg      <= in_err;
                    lo_reg       <= BW'(in_start);
                    hi_reg       <= (in_mode == bbre_pkg::MODE_TAS)
                                    ? (BW+1)'(in_start) + 1'b1 : in_end;
                    idx_reg      <= '0;
                    val_reg      <= '0;
                    rs_reg       <= '0;
                    in_run_reg   <= 1'b0;
                    done_run_reg <= 1'b0;
                end
                bbre_pkg::ST_WORK: begin
                    idx_reg <= idx_reg + 1'b1;
                    val_reg <= val_next;
                    rs_reg  <= rs_next;
                    if (!err_reg) begin
                        if (mode_reg == bbre_pkg::MODE_INIT ||
                            mode_reg == bbre_pkg::MODE_ADD ||
                            mode_reg == bbre_pkg::MODE_TAS ||
                            mode_reg == bbre_pkg::MODE_EXTR)
                            valid_reg[widx] <= 1'b1;
                        if (mode_reg == bbre_pkg::MODE_EXTR && !done_run_reg) begin
                            if (in_run_reg || found) begin
                                in_run_reg <= 1'b1;
                                if (run_ends) done_run_reg <= 1'b1;
                            end
                        end
                    end
                    if (last_word) begin
                        out_v_reg <= 1'b1;
                        out_reg   <= {2'b0, err_reg, rs_next, val_next};
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> !s_tready) else $error("accept while result pending");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= (AW+1)'(NW)) else $error("word index overrun");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbre_pkg::ST_WORK && last_word) |=> out_v_reg)
        else $error("result missing");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");
endmodule

[dv/block_bitmap_range_engine_tb.sv]
`timescale 1ns / 1ps

module block_bitmap_range_engine_tb;

    localparam int NBLK = 1024;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int RW = bbre_pkg::RESULT_W;
    localparam int SW = bbre_pkg::START_W;
    localparam int CW = bbre_pkg::COUNT_W;

    typedef struct packed {
        logic          err;
        logic [SW-1:0] rstart;
        logic [RW-1:0] value;
    } alloc_res_t;

    class alloc_scoreboard;
        bit         blk_map [NBLK];
        alloc_res_t pending[$];
        int         fails;

        function new();
            foreach (blk_map[i]) blk_map[i] = 0;
            fails = 0;
        endfunction

        function bit range_legal(int unsigned st, int unsigned cnt);
            return cnt > 0 && st < NBLK && cnt <= NBLK - st;
        endfunction

        function void note_request(logic [2:0] md, logic [SW-1:0] st,
                                   logic [CW-1:0] cnt);
            alloc_res_t r;
            int b;
            r = '0;
            case (md)
                bbre_pkg::MODE_INIT, bbre_pkg::MODE_ADD: begin
                    if (!range_legal(st, cnt)) r.err = 1;
                    else begin
                        if (md == bbre_pkg::MODE_INIT)
                            foreach (blk_map[i]) blk_map[i] = 0;
                        for (int k = 0; k < cnt; k++) blk_map[st + k] = 1;
                    end
                end
                bbre_pkg::MODE_TAS: begin
                    r.value = RW'(blk_map[st]);
                    blk_map[st] = 1;
                end
                bbre_pkg::MODE_EXTR: begin
                    b = 0;
                    while (b < NBLK && !blk_map[b]) b++;
                    if (b < NBLK) begin
                        r.rstart = SW'(b);
                        while (b < NBLK && blk_map[b]) begin
                            blk_map[b] = 0;
                            r.value++;
                            b++;
                        end
                    end
                end
                bbre_pkg::MODE_COUNT: begin
                    if (!range_legal(st, cnt)) r.err = 1;
                    else for (int k = 0; k < cnt; k++)
                        r.value += RW'(blk_map[st + k]);
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] d);
            alloc_res_t got, exp;
            got = d[21:0];
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", d);
                fails++;
                return;
            end
            exp = pending.pop_front();
            if (got.value !== exp.value) begin
                $error("result_value exp %0d got %0d", exp.value, got.value);
                fails++;
            end
            if (got.rstart !== exp.rstart) begin
                $error("run_start exp %0d got %0d", exp.rstart, got.rstart);
                fails++;
            end
            if (got.err !== exp.err) begin
                $error("range_error exp %0d got %0d", exp.err, got.err);
                fails++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;

    alloc_scoreboard sb = new();
    int          cycles = 0;
    int          burst_left = 0;
    int          stall_mode = 0;

    always #10 aclk = ~aclk;

    block_bitmap_range_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // receiver: stall pattern changes every so often, with clean stretches
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_req(logic [2:0] md, logic [SW-1:0] st,
                            logic [CW-1:0] cnt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {cnt, st, md};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(md, st, cnt);
        s_tvalid <= 1'b0;
        // hold valid low before the next beat is offered
        @(posedge aclk);
    endtask

    task automatic drain_wait();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    task automatic rand_req();
        int pick;
        logic [2:0] md;
        logic [SW-1:0] st;
        logic [CW-1:0] cnt;
        pick = $urandom_range(0, 99);
        st = SW'($urandom);
        if (pick < 20) md = bbre_pkg::MODE_ADD;
        else if (pick < 25) md = bbre_pkg::MODE_INIT;
        else if (pick < 45) md = bbre_pkg::MODE_TAS;
        else if (pick < 65) md = bbre_pkg::MODE_EXTR;
        else if (pick < 92) md = bbre_pkg::MODE_COUNT;
        else md = 3'($urandom_range(5, 7));
        case ($urandom_range(0, 9))
            0: cnt = CW'($urandom);
            1: cnt = CW'(NBLK - st + $urandom_range(0, 1));
            2: cnt = '0;
            3, 4: cnt = CW'($urandom_range(1, NBLK - st));
            default: cnt = CW'($urandom_range(1, (NBLK - st) < 40 ? NBLK - st : 40));
        endcase
        send_req(md, st, cnt);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed
        send_req(bbre_pkg::MODE_EXTR, 0, 0);
        send_req(bbre_pkg::MODE_COUNT, 0, 1024);
        send_req(bbre_pkg::MODE_INIT, 0, 1024);
        send_req(bbre_pkg::MODE_COUNT, 0, 1024);
        send_req(bbre_pkg::MODE_EXTR, 0, 0);
        send_req(bbre_pkg::MODE_INIT, 1023, 1);
        send_req(bbre_pkg::MODE_TAS, 1023, 0);
        send_req(bbre_pkg::MODE_TAS, 0, 0);
        send_req(bbre_pkg::MODE_ADD, 60, 10);
        send_req(bbre_pkg::MODE_COUNT, 0, 1024);
        send_req(bbre_pkg::MODE_EXTR, 10'h3FF, 11'h7FF);
        send_req(bbre_pkg::MODE_EXTR, 0, 0);
        send_req(bbre_pkg::MODE_ADD, 1000, 24);
        send_req(bbre_pkg::MODE_EXTR, 0, 0);
        send_req(bbre_pkg::MODE_ADD, 1000, 25);
        send_req(bbre_pkg::MODE_INIT, 5, 0);
        send_req(bbre_pkg::MODE_COUNT, 1023, 2);
        send_req(bbre_pkg::MODE_ADD, 0, 11'h7FF);
        send_req(bbre_pkg::MODE_COUNT, 1023, 1);
        send_req(3'd5, 10'h3FF, 11'h7FF);
        send_req(3'd6, 0, 0);
        send_req(3'd7, 10'h155, 11'h2AA);
        drain_wait();
        // random
        for (int i = 0; i < 1550; i++) begin
            rand_req();
            if (i == 700) drain_wait();
        end
        drain_wait();
        repeat (200) @(posedge aclk);
        if (sb.pending.size() == 0 && sb.fails == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
